// File: rtl/core/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked property, skipped while reset is high
`define CHK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property with no reset qualifier
`define CHK_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_RST(lbl, clk, rst, prop, msg)
`define CHK_ANY(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/core/tpl_pkg.sv
// shared types and constants of the three phase level block
`default_nettype none
package tpl_pkg;

  localparam int unsigned TRIM_W = 24;
  localparam logic [23:0] QUARTER_TURN = 24'h400000;
  localparam logic [31:0] SQRT3_HALF_Q30 = 32'd929887696;

  // odd sine series coefficients, q30
  localparam logic [31:0] SIN_K1  = 32'd1686629713;
  localparam logic [31:0] SIN_K3  = 32'd693598663;
  localparam logic [31:0] SIN_K5  = 32'd85569306;
  localparam logic [31:0] SIN_K7  = 32'd5026995;
  localparam logic [31:0] SIN_K9  = 32'd172272;
  localparam logic [31:0] SIN_K11 = 32'd3864;

  typedef enum logic {
    REG_TRIM_B = 1'b0,
    REG_TRIM_C = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    TRIG_IDLE = 2'b01,
    TRIG_RUN  = 2'b10
  } trig_state_t;

  typedef struct packed {
    logic signed [31:0] sin_b;
    logic signed [31:0] cos_b;
    logic signed [31:0] sin_c;
    logic signed [31:0] cos_c;
  } trig_set_t;

endpackage
`default_nettype wire

// File: rtl/core/three_phase_levels_from_alpha_beta_top.sv
// top level: inverse clarke levels with per-phase angle trim
// done follows an accepted start via v1-v4; one item per cycle while busy
// is low; the sine/cosine unit runs after reset and after every register
// write, one multiply step a cycle; busy stays high during that run
// reset (rst, synchronous) clears trims to zero, empties the pipeline and
// starts the sine/cosine run; results cannot be stalled by the receiver
`default_nettype none
`include "assert_macros.svh"
module three_phase_levels_from_alpha_beta_top
  import tpl_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // item handshake
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] alpha_in,
  input  wire logic signed [31:0] beta_in,
  input  wire logic signed [31:0] gain_in,
  output logic                    done,
  output logic signed [31:0]      a_top,
  output logic signed [31:0]      a_bottom,
  output logic signed [31:0]      b_top,
  output logic signed [31:0]      b_bottom,
  output logic signed [31:0]      c_top,
  output logic signed [31:0]      c_bottom
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [31:0] HALF_NEG = -(ONE >>> 1);
  localparam logic signed [31:0] K866 = 32'(SQRT3_HALF_Q30 >> (30 - FRACTION_BITS));

  // fixed-point multiply, floor, low 32 bits of the shifted product kept
  function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return p[FRACTION_BITS+31:FRACTION_BITS];
  endfunction

  // ---------------- register port ----------------
  logic [TRIM_W-1:0] trim_b;
  logic [TRIM_W-1:0] trim_c;
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  logic [TRIM_W-1:0] wr_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_val  = pwdata[TRIM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_b <= '0;
      trim_c <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIM_B: trim_b <= wr_val;
        REG_TRIM_C: trim_c <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIM_B: prdata = {8'b0, trim_b};
      REG_TRIM_C: prdata = {8'b0, trim_c};
      default:    prdata = '0;
    endcase
  end

  // ---------------- sine/cosine of the trims ----------------
  logic      trig_busy;
  trig_set_t trig;

  tpl_trig #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_trig (
    .clk    (clk),
    .rst    (rst),
    .kick   (cfg_wr),
    .trim_b (trim_b),
    .trim_c (trim_c),
    .busy   (trig_busy),
    .trig   (trig)
  );

  // a write in flight also holds off items so they see the new trims
  assign busy = rst | trig_busy | cfg_wr;

  logic accept;
  assign accept = start & ~busy;

  // ---------------- pipeline ----------------
  logic v1, v2, v3, v4;

  // stage 1: captured beat
  logic signed [31:0] al1, be1, k1;
  // stage 2: rotation products and phase a gain products
  logic signed [31:0] p_acb, p_bsb, p_bcb, p_asb;
  logic signed [31:0] p_acc, p_bsc, p_bcc, p_asc;
  logic signed [31:0] a_hi2, a_lo2, k2;
  // stage 3: projection products, phase a levels
  logic signed [31:0] t1b, t2b, t1c, t2c;
  logic signed [31:0] a_top3, a_bot3, k3;
  // stage 4: gain products of phases b and c
  logic signed [31:0] b_hi4, b_lo4, c_hi4, c_lo4;
  logic signed [31:0] a_top4, a_bot4;

  logic signed [31:0] xb, xc;
  assign xb = t1b + t2b;
  assign xc = t1c - t2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      al1 <= alpha_in;
      be1 <= beta_in;
      k1  <= gain_in;
    end
    if (v1) begin
      p_acb <= qmul(al1, trig.cos_b);
      p_bsb <= qmul(be1, trig.sin_b);
      p_bcb <= qmul(be1, trig.cos_b);
      p_asb <= qmul(al1, trig.sin_b);
      p_acc <= qmul(al1, trig.cos_c);
      p_bsc <= qmul(be1, trig.sin_c);
      p_bcc <= qmul(be1, trig.cos_c);
      p_asc <= qmul(al1, trig.sin_c);
      a_hi2 <= qmul(k1, al1 - ONE);
      a_lo2 <= qmul(k1, al1 + ONE);
      k2    <= k1;
    end
    if (v2) begin
      t1b    <= qmul(HALF_NEG, p_acb - p_bsb);
      t2b    <= qmul(K866, p_bcb + p_asb);
      t1c    <= qmul(HALF_NEG, p_acc - p_bsc);
      t2c    <= qmul(K866, p_bcc + p_asc);
      a_top3 <= ONE + (a_hi2 >>> 1);
      a_bot3 <= -ONE + (a_lo2 >>> 1);
      k3     <= k2;
    end
    if (v3) begin
      b_hi4  <= qmul(k3, xb - ONE);
      b_lo4  <= qmul(k3, xb + ONE);
      c_hi4  <= qmul(k3, xc - ONE);
      c_lo4  <= qmul(k3, xc + ONE);
      a_top4 <= a_top3;
      a_bot4 <= a_bot3;
    end
    if (v4) begin
      a_top    <= a_top4;
      a_bottom <= a_bot4;
      b_top    <= ONE + (b_hi4 >>> 1);
      b_bottom <= -ONE + (b_lo4 >>> 1);
      c_top    <= ONE + (c_hi4 >>> 1);
      c_bottom <= -ONE + (c_lo4 >>> 1);
    end
  end

  // ---------------- checks ----------------
  logic wr_trim_b;
  assign wr_trim_b = cfg_wr & (reg_idx == REG_TRIM_B);

  `CHK_RST(a_done_follows, clk, rst, accept |-> ##5 done, "accepted beat lost")
  `CHK_RST(a_done_source, clk, rst, done |-> $past(accept, 5), "result without a beat")
  `CHK_RST(a_trim_b_wr, clk, rst, wr_trim_b |=> trim_b == $past(wr_val), "trim b write lost")

endmodule
`default_nettype wire

// File: rtl/core/tpl_trig.sv
// sequential sine/cosine unit for the two trim angles, one shared multiplier
`default_nettype none
module tpl_trig
  import tpl_pkg::*;
#(
  parameter int FRACTION_BITS = 24
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              kick,
  input  wire logic [TRIM_W-1:0] trim_b,
  input  wire logic [TRIM_W-1:0] trim_c,
  output logic                   busy,
  output trig_set_t              trig
);

  localparam int RND_SHIFT = 30 - FRACTION_BITS;
  localparam logic [32:0] ROUND_HALF = 33'((64'd1 << RND_SHIFT) >> 1);
  localparam logic [32:0] ONE_33 = 33'(64'd1 << FRACTION_BITS);
  localparam logic [2:0] LAST_STEP = 3'd6;

  trig_state_t state;
  logic [1:0]  ang_idx;
  logic [2:0]  step;
  logic [31:0] u2;
  logic [31:0] poly;

  logic [23:0] ang;
  logic [22:0] off;
  logic [31:0] u;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] coef;
  logic [32:0] rounded;
  logic [32:0] clamped;
  logic [31:0] sval;

  always_comb begin
    ang = ang_idx[1] ? trim_c : trim_b;
    if (ang_idx[0]) begin
      ang = ang + QUARTER_TURN;
    end
    off = ang[22] ? (23'h400000 - {1'b0, ang[21:0]}) : {1'b0, ang[21:0]};
    u = {1'b0, off, 8'b0};
  end

  always_comb begin
    unique case (step)
      3'd1:    coef = SIN_K9;
      3'd2:    coef = SIN_K7;
      3'd3:    coef = SIN_K5;
      3'd4:    coef = SIN_K3;
      3'd5:    coef = SIN_K1;
      default: coef = '0;
    endcase
    mul_a = (step == 3'd0 || step == LAST_STEP) ? u : u2;
    mul_b = (step == 3'd0) ? u : ((step == 3'd1) ? SIN_K11 : poly);
    prod  = 64'(mul_a) * 64'(mul_b);
    rounded = ({1'b0, prod[61:30]} + ROUND_HALF) >> RND_SHIFT;
    clamped = (rounded > ONE_33) ? ONE_33 : rounded;
    sval = ang[23] ? (32'd0 - clamped[31:0]) : clamped[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= TRIG_RUN;
      ang_idx <= '0;
      step    <= '0;
    end else if (kick) begin
      state   <= TRIG_RUN;
      ang_idx <= '0;
      step    <= '0;
    end else if (state == TRIG_RUN) begin
      if (step == LAST_STEP) begin
        step    <= '0;
        ang_idx <= ang_idx + 2'd1;
        if (ang_idx == 2'd3) begin
          state <= TRIG_IDLE;
        end
      end else begin
        step <= step + 3'd1;
      end
    end
  end

  // datapath registers of the series evaluation
  always_ff @(posedge clk) begin
    if (state == TRIG_RUN) begin
      if (step == 3'd0) begin
        u2 <= prod[61:30];
      end else if (step == LAST_STEP) begin
        unique case (ang_idx)
          2'd0: trig.sin_b <= sval;
          2'd1: trig.cos_b <= sval;
          2'd2: trig.sin_c <= sval;
          2'd3: trig.cos_c <= sval;
          default: ;
        endcase
      end else begin
        poly <= coef - prod[61:30];
      end
    end
  end

  assign busy = (state == TRIG_RUN);

endmodule
`default_nettype wire
